// ===== hw/rtl/ltda_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ltda_pkg;

    localparam int NUM_LINKS  = 16;
    localparam int LINK_W     = (NUM_LINKS > 1) ? $clog2(NUM_LINKS) : 1;
    localparam int TIME_W     = 48;
    localparam int CNT_W      = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_BYTE_TIME      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_BYTES   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LINK_DELAY     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_BYTES   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TRANSFER_BYTES = 3'd4;

    localparam logic [31:0] RST_BYTE_TIME      = 32'd65536;
    localparam logic [23:0] RST_BUFFER_BYTES   = 24'd65536;
    localparam logic [31:0] RST_LINK_DELAY     = 32'd0;
    localparam logic [15:0] RST_HEADER_BYTES   = 16'd40;
    localparam logic [15:0] RST_TRANSFER_BYTES = 16'd1500;

    typedef struct packed {
        logic [31:0] byte_time;
        logic [23:0] buffer_bytes;
        logic [31:0] link_delay;
        logic [15:0] header_bytes;
        logic [15:0] transfer_bytes;
    } t_cfg;

    typedef struct packed {
        logic [TIME_W-1:0] now;
        logic [LINK_W-1:0] link;
        logic              packet_kind;
        logic [15:0]       jitter;
        logic [15:0]       source;
        logic [15:0]       destination;
        logic [31:0]       sequence_req;
        logic [31:0]       acknowledge;
    } t_item;

    typedef struct packed {
        logic              forwarded;
        logic [TIME_W-1:0] arrival_delay;
        logic [TIME_W-1:0] prev_finish;
        logic [15:0]       source_out;
        logic [15:0]       destination_out;
        logic [31:0]       sequence_out;
        logic [31:0]       acknowledge_out;
        logic [CNT_W-1:0]  drop_total;
    } t_result;

    // stage enables from the sequencer to the datapath
    typedef struct packed {
        logic load;
        logic mul;
        logic sum;
        logic commit;
    } t_step;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_COMMIT
    } t_state;

    function automatic logic [LINK_W-1:0] link_index(input logic [3:0] link);
        return LINK_W'(int'(link) % NUM_LINKS);
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ltda_cfg_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ltda_cfg_regs (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_wr_en,
    input  wire logic [ltda_pkg::CFG_IDX_W-1:0]   i_wr_index,
    input  wire logic [ltda_pkg::CFG_DATA_W-1:0]  i_wr_data,
    output ltda_pkg::t_cfg                        o_cfg
);
    import ltda_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.byte_time      <= RST_BYTE_TIME;
            r_cfg.buffer_bytes   <= RST_BUFFER_BYTES;
            r_cfg.link_delay     <= RST_LINK_DELAY;
            r_cfg.header_bytes   <= RST_HEADER_BYTES;
            r_cfg.transfer_bytes <= RST_TRANSFER_BYTES;
        end else if (i_wr_en) begin
            case (i_wr_index)
                CFG_BYTE_TIME:      r_cfg.byte_time      <= i_wr_data;
                CFG_BUFFER_BYTES:   r_cfg.buffer_bytes   <= i_wr_data[23:0];
                CFG_LINK_DELAY:     r_cfg.link_delay     <= i_wr_data;
                CFG_HEADER_BYTES:   r_cfg.header_bytes   <= i_wr_data[15:0];
                CFG_TRANSFER_BYTES: r_cfg.transfer_bytes <= i_wr_data[15:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== hw/rtl/ltda_finish_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ltda_finish_mem (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_rd_en,
    input  wire logic [ltda_pkg::LINK_W-1:0]   i_rd_addr,
    output logic      [ltda_pkg::TIME_W-1:0]   o_rd_data,
    input  wire logic                          i_wr_en,
    input  wire logic [ltda_pkg::LINK_W-1:0]   i_wr_addr,
    input  wire logic [ltda_pkg::TIME_W-1:0]   i_wr_data
);
    import ltda_pkg::*;

    logic [TIME_W-1:0]    r_mem [NUM_LINKS];
    logic [NUM_LINKS-1:0] r_valid;
    logic [TIME_W-1:0]    r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // a link never written reads as finish time zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_valid[i_rd_addr] ? r_mem[i_rd_addr] : '0;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== hw/rtl/ltda_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ltda_datapath (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  ltda_pkg::t_step                    i_step,
    input  ltda_pkg::t_cfg                     i_cfg,
    input  ltda_pkg::t_item                    i_item,
    input  wire logic [ltda_pkg::TIME_W-1:0]   i_old_finish,
    output logic                               o_wr_en,
    output logic      [ltda_pkg::LINK_W-1:0]   o_wr_addr,
    output logic      [ltda_pkg::TIME_W-1:0]   o_wr_data,
    output ltda_pkg::t_result                  o_result
);
    import ltda_pkg::*;

    t_item             r_item;

    // multiply stage
    logic [15:0]       size;
    logic [23:0]       room;
    logic [TIME_W-1:0] tx;
    logic [55:0]       lim;
    logic [TIME_W-1:0] r_old;
    logic [TIME_W-1:0] r_q;
    logic [TIME_W-1:0] r_tx;
    logic [55:0]       r_lim;
    logic              r_idle;
    logic              r_fits;

    // sum stage
    logic [TIME_W:0]   r_txj;
    logic [TIME_W:0]   r_ql;
    logic [TIME_W-1:0] r_base;
    logic              r_accept;

    // commit stage
    logic [TIME_W-1:0] new_finish;
    logic [TIME_W+1:0] dsum;
    logic [TIME_W-1:0] delay;
    logic [CNT_W-1:0]  r_drop;
    logic [CNT_W-1:0]  n_drop;
    t_result           r_result;

    always_ff @(posedge i_clk) begin
        if (i_step.load) begin
            r_item <= i_item;
        end
    end

    always_comb begin
        size = r_item.packet_kind ? i_cfg.transfer_bytes : i_cfg.header_bytes;
        room = i_cfg.buffer_bytes - {8'd0, size};
        tx   = TIME_W'(size) * TIME_W'(i_cfg.byte_time);
        lim  = 56'(room) * 56'(i_cfg.byte_time);
    end

    always_ff @(posedge i_clk) begin
        if (i_step.mul) begin
            r_old  <= i_old_finish;
            r_idle <= r_item.now > i_old_finish;
            r_q    <= i_old_finish - r_item.now;
            r_tx   <= tx;
            r_lim  <= lim;
            r_fits <= {8'd0, size} <= i_cfg.buffer_bytes;
        end
    end

    // busy link: queued time must fit the room left after this packet
    always_ff @(posedge i_clk) begin
        if (i_step.sum) begin
            r_accept <= r_idle || (r_fits && ({8'd0, r_q} <= r_lim));
            r_txj    <= {1'b0, r_tx} + {{(TIME_W - 15){1'b0}}, r_item.jitter};
            r_ql     <= (r_idle ? '0 : {1'b0, r_q})
                        + {{(TIME_W - 31){1'b0}}, i_cfg.link_delay};
            r_base   <= r_idle ? r_item.now : r_old;
        end
    end

    always_comb begin
        new_finish = r_base + r_txj[TIME_W-1:0];
        dsum       = {1'b0, r_txj} + {1'b0, r_ql};
        delay      = (dsum[TIME_W+1:TIME_W] != 2'd0) ? '1 : dsum[TIME_W-1:0];
        n_drop     = r_drop;
        if (!r_accept && r_drop != '1) begin
            n_drop = r_drop + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drop <= '0;
        end else if (i_step.commit) begin
            r_drop <= n_drop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step.commit) begin
            r_result.forwarded       <= r_accept;
            r_result.arrival_delay   <= r_accept ? delay : '0;
            r_result.prev_finish     <= r_old;
            r_result.source_out      <= r_accept ? r_item.source : '0;
            r_result.destination_out <= r_accept ? r_item.destination : '0;
            r_result.sequence_out    <= r_accept ? r_item.sequence_req : '0;
            r_result.acknowledge_out <= r_accept ? r_item.acknowledge : '0;
            r_result.drop_total      <= n_drop;
        end
    end

    assign o_wr_en   = i_step.commit && r_accept;
    assign o_wr_addr = r_item.link;
    assign o_wr_data = new_finish;
    assign o_result  = r_result;

endmodule

`default_nettype wire

// ===== hw/rtl/link_tail_drop_admission.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel   handshake                    payload
// ------    ---------------------------  -------------------------------------------
// item in   start, busy (take: start&!busy) i_now i_link i_packet_kind i_jitter
//                                        i_source i_destination i_sequence_req
//                                        i_acknowledge
// result    o_done (one-cycle strobe)    o_forwarded o_arrival_delay o_prev_finish
//                                        o_source_out o_destination_out
//                                        o_sequence_out o_acknowledge_out o_drop_total
// config    i_cfg_valid, o_cfg_ready     i_cfg_index i_cfg_data
//
// Per item: finish-time memory read, multiply, sum, commit/write-back; busy stays high
// through commit. The result strobe is registered from the commit state; busy drops as the
// result registers load, so the next item may be taken while o_done is high.
// The per-link read-modify-write is serialized by busy: no overlap on the memory.
// Synchronous active-low reset clears all finish times (valid bits), the drop
// counter and the config registers; no clearing pass. The receiver cannot stall.
module link_tail_drop_admission (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic [47:0]                      i_now,
    input  wire logic [3:0]                       i_link,
    input  wire logic                             i_packet_kind,
    input  wire logic [15:0]                      i_jitter,
    input  wire logic [15:0]                      i_source,
    input  wire logic [15:0]                      i_destination,
    input  wire logic [31:0]                      i_sequence_req,
    input  wire logic [31:0]                      i_acknowledge,
    output logic                                  o_done,
    output logic                                  o_forwarded,
    output logic      [47:0]                      o_arrival_delay,
    output logic      [47:0]                      o_prev_finish,
    output logic      [15:0]                      o_source_out,
    output logic      [15:0]                      o_destination_out,
    output logic      [31:0]                      o_sequence_out,
    output logic      [31:0]                      o_acknowledge_out,
    output logic      [31:0]                      o_drop_total,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [ltda_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [ltda_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import ltda_pkg::*;

    t_state            r_state;
    t_state            n_state;
    logic              r_done;
    logic              accept;
    t_step             step;
    t_cfg              cfg;
    t_item             item;
    t_result           result;
    logic [TIME_W-1:0] rd_data;
    logic              wr_en;
    logic [LINK_W-1:0] wr_addr;
    logic [TIME_W-1:0] wr_data;

    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= step.commit;
        end
    end

    always_comb begin
        n_state     = r_state;
        step        = '0;
        busy        = 1'b1;
        case (r_state)
            ST_IDLE: begin
                busy      = 1'b0;
                step.load = start;
                if (start) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                step.mul = 1'b1;
                n_state  = ST_SUM;
            end
            ST_SUM: begin
                step.sum = 1'b1;
                n_state  = ST_COMMIT;
            end
            ST_COMMIT: begin
                step.commit = 1'b1;
                n_state     = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        item.now          = i_now;
        item.link         = link_index(i_link);
        item.packet_kind  = i_packet_kind;
        item.jitter       = i_jitter;
        item.source       = i_source;
        item.destination  = i_destination;
        item.sequence_req = i_sequence_req;
        item.acknowledge  = i_acknowledge;
    end

    ltda_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    ltda_finish_mem u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_addr (item.link),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    ltda_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_cfg        (cfg),
        .i_item       (item),
        .i_old_finish (rd_data),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data),
        .o_result     (result)
    );

    assign o_cfg_ready       = 1'b1;
    assign o_done            = r_done;
    assign o_forwarded       = result.forwarded;
    assign o_arrival_delay   = result.arrival_delay;
    assign o_prev_finish     = result.prev_finish;
    assign o_source_out      = result.source_out;
    assign o_destination_out = result.destination_out;
    assign o_sequence_out    = result.sequence_out;
    assign o_acknowledge_out = result.acknowledge_out;
    assign o_drop_total      = result.drop_total;

    a_done_after_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state == ST_COMMIT))
        else $error("result strobe without a commit");

    a_drop_clears_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !o_forwarded |-> o_arrival_delay == '0 && o_source_out == '0
            && o_sequence_out == '0)
        else $error("dropped item carries payload");

    a_drop_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !o_forwarded |-> o_drop_total != '0)
        else $error("drop not counted");

    a_no_write_while_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> r_state == ST_COMMIT && !accept)
        else $error("finish write outside commit");

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import ltda_pkg::*;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

    // one line of the directed plan: either a packet or a register write
    typedef struct packed {
        row_kind_e             kind;
        t_item                 it;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        logic                  typed;
        logic                  fwd;
        logic [TIME_W-1:0]     dly;
        logic [TIME_W-1:0]     prev;
        logic [CNT_W-1:0]      drops;
    } stim_row_t;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    logic                  i_clk;
    logic                  i_rst_n   = 1'b0;
    logic                  start     = 1'b0;
    logic                  busy;
    t_item                 drv       = '0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  o_cfg_ready;
    logic                  o_done;
    logic                  o_forwarded;
    logic [47:0]           o_arrival_delay;
    logic [47:0]           o_prev_finish;
    logic [15:0]           o_source_out;
    logic [15:0]           o_destination_out;
    logic [31:0]           o_sequence_out;
    logic [31:0]           o_acknowledge_out;
    logic [31:0]           o_drop_total;

    // shadow of the block: registers, per-link finish times, drop counter
    t_cfg              regs;
    logic [TIME_W-1:0] link_finish [NUM_LINKS];
    logic [CNT_W-1:0]  drops_seen;
    t_result           pending_results [$];
    int                mismatches = 0;
    logic              idle_on    = 1'b1;

    link_tail_drop_admission DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_now             (drv.now),
        .i_link            (drv.link),
        .i_packet_kind     (drv.packet_kind),
        .i_jitter          (drv.jitter),
        .i_source          (drv.source),
        .i_destination     (drv.destination),
        .i_sequence_req    (drv.sequence_req),
        .i_acknowledge     (drv.acknowledge),
        .o_done            (o_done),
        .o_forwarded       (o_forwarded),
        .o_arrival_delay   (o_arrival_delay),
        .o_prev_finish     (o_prev_finish),
        .o_source_out      (o_source_out),
        .o_destination_out (o_destination_out),
        .o_sequence_out    (o_sequence_out),
        .o_acknowledge_out (o_acknowledge_out),
        .o_drop_total      (o_drop_total),
        .i_cfg_valid       (cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    // tail-drop decision for one packet; updates the shadow link state
    function automatic t_result admit_packet(input t_item it);
        logic [63:0] size;
        logic [63:0] tx;
        logic [63:0] q;
        logic [63:0] sum;
        logic        take;
        int          ln;
        t_result     r;
        ln   = int'(it.link) % NUM_LINKS;
        size = it.packet_kind ? 64'(regs.transfer_bytes) : 64'(regs.header_bytes);
        tx   = size * 64'(regs.byte_time);
        r    = '0;
        r.prev_finish = link_finish[ln];
        if (it.now > link_finish[ln]) begin
            take = 1'b1;
            sum  = tx + 64'(it.jitter) + 64'(regs.link_delay);
            link_finish[ln] = TIME_W'(64'(it.now) + tx + 64'(it.jitter));
        end else begin
            q    = 64'(link_finish[ln] - it.now);
            take = size <= 64'(regs.buffer_bytes)
                && q <= (64'(regs.buffer_bytes) - size) * 64'(regs.byte_time);
            sum  = q + tx + 64'(it.jitter) + 64'(regs.link_delay);
            if (take)
                link_finish[ln] = TIME_W'(64'(link_finish[ln]) + tx + 64'(it.jitter));
        end
        if (take) begin
            r.forwarded       = 1'b1;
            r.arrival_delay   = (sum > 64'(TIME_MAX)) ? TIME_MAX : TIME_W'(sum);
            r.source_out      = it.source;
            r.destination_out = it.destination;
            r.sequence_out    = it.sequence_req;
            r.acknowledge_out = it.acknowledge;
        end else if (drops_seen != '1) begin
            drops_seen = drops_seen + 1'b1;
        end
        r.drop_total = drops_seen;
        return r;
    endfunction

    function automatic stim_row_t item_row(input logic [47:0] now, input logic [3:0] link,
                                           input logic kind, input logic [15:0] jit,
                                           input logic [31:0] tag);
        stim_row_t r;
        r                  = '0;
        r.kind             = ROW_ITEM;
        r.it.now           = now;
        r.it.link          = link;
        r.it.packet_kind   = kind;
        r.it.jitter        = jit;
        r.it.source        = tag[15:0];
        r.it.destination   = ~tag[15:0];
        r.it.sequence_req  = tag;
        r.it.acknowledge   = ~tag;
        return r;
    endfunction

    function automatic stim_row_t typed_row(input stim_row_t r, input logic fwd,
                                            input logic [47:0] dly, input logic [47:0] prev,
                                            input logic [31:0] drops);
        stim_row_t t;
        t       = r;
        t.typed = 1'b1;
        t.fwd   = fwd;
        t.dly   = dly;
        t.prev  = prev;
        t.drops = drops;
        return t;
    endfunction

    function automatic stim_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] val);
        stim_row_t r;
        r         = '0;
        r.kind    = ROW_CFG;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    task automatic check_field(input string fname, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t %s expected %0h actual %0h", $time, fname, want, got);
        end
    endtask

    // valid stays high across back-to-back writes; the next item lowers it
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        case (idx)
            CFG_BYTE_TIME:      regs.byte_time      = val;
            CFG_BUFFER_BYTES:   regs.buffer_bytes   = val[23:0];
            CFG_LINK_DELAY:     regs.link_delay     = val;
            CFG_HEADER_BYTES:   regs.header_bytes   = val[15:0];
            CFG_TRANSFER_BYTES: regs.transfer_bytes = val[15:0];
            default: ;
        endcase
    endtask

    task automatic settle();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_item(input stim_row_t row);
        t_result want;
        start     <= 1'b1;
        drv       <= row.it;
        cfg_valid <= 1'b0;
        do @(posedge i_clk); while (busy !== 1'b0);
        want = admit_packet(row.it);
        if (row.typed) begin
            want.forwarded     = row.fwd;
            want.arrival_delay = row.dly;
            want.prev_finish   = row.prev;
            want.drop_total    = row.drops;
        end
        pending_results.push_back(want);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n === 1'b1 && o_done === 1'b1) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                $display("%0t result with none expected, actual prev_finish %0h drop_total %0h",
                         $time, o_prev_finish, o_drop_total);
            end else begin
                want = pending_results.pop_front();
                check_field("forwarded", 64'(want.forwarded), 64'(o_forwarded));
                check_field("arrival_delay", 64'(want.arrival_delay), 64'(o_arrival_delay));
                check_field("prev_finish", 64'(want.prev_finish), 64'(o_prev_finish));
                check_field("source_out", 64'(want.source_out), 64'(o_source_out));
                check_field("destination_out", 64'(want.destination_out),
                            64'(o_destination_out));
                check_field("sequence_out", 64'(want.sequence_out), 64'(o_sequence_out));
                check_field("acknowledge_out", 64'(want.acknowledge_out),
                            64'(o_acknowledge_out));
                check_field("drop_total", 64'(want.drop_total), 64'(o_drop_total));
            end
        end
    end

    initial begin
        stim_row_t         plan [$];
        stim_row_t         row;
        t_cfg              next_cfg;
        logic [TIME_W-1:0] clock_now;
        logic [63:0]       stride;
        regs = '{RST_BYTE_TIME, RST_BUFFER_BYTES, RST_LINK_DELAY, RST_HEADER_BYTES,
                 RST_TRANSFER_BYTES};
        foreach (link_finish[i])
            link_finish[i] = '0;
        drops_seen = '0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: idle link, arrival equal to finish, finish wrapping past the top
        plan.push_back(typed_row(item_row(48'h1_0000, 4'd0, 1'b0, 16'h0, 32'h0),
                                 1'b1, 48'd2621440, 48'd0, 32'd0));
        plan.push_back(typed_row(item_row(48'h0, 4'd1, 1'b1, 16'hFFFF, 32'hFFFF_FFFF),
                                 1'b1, 48'd98369535, 48'd0, 32'd0));
        plan.push_back(typed_row(item_row(TIME_MAX, 4'd15, 1'b1, 16'hFFFF, 32'h1234_5678),
                                 1'b1, 48'd98369535, 48'd0, 32'd0));
        plan.push_back(item_row(48'h0, 4'd15, 1'b0, 16'h0, 32'hA5A5_5A5A));
        plan.push_back(item_row(48'h1_0000, 4'd0, 1'b1, 16'h5, 32'h0F0F_F0F0));
        // no buffer: any busy link drops, idle links still send
        plan.push_back(cfg_row(CFG_BUFFER_BYTES, 32'h0));
        plan.push_back(typed_row(item_row(48'h0, 4'd1, 1'b0, 16'h0, 32'h0),
                                 1'b0, 48'd0, 48'd98369535, 32'd1));
        plan.push_back(item_row(TIME_MAX, 4'd2, 1'b0, 16'h0, 32'hFFFF_FFFF));
        // zero transmit time: busy link takes a packet only with nothing queued
        plan.push_back(cfg_row(CFG_BUFFER_BYTES, 32'h00FF_FFFF));
        plan.push_back(cfg_row(CFG_BYTE_TIME, 32'h0));
        plan.push_back(typed_row(item_row(48'd5, 4'd3, 1'b1, 16'h0, 32'h1),
                                 1'b1, 48'd0, 48'd0, 32'd1));
        plan.push_back(typed_row(item_row(48'd5, 4'd3, 1'b1, 16'h7, 32'h2),
                                 1'b1, 48'd7, 48'd5, 32'd1));
        plan.push_back(typed_row(item_row(48'd5, 4'd3, 1'b0, 16'h0, 32'h3),
                                 1'b0, 48'd0, 48'd12, 32'd2));
        // everything at the top: delay lands exactly on the limit, then saturates
        plan.push_back(cfg_row(CFG_BYTE_TIME, 32'hFFFF_FFFF));
        plan.push_back(cfg_row(CFG_LINK_DELAY, 32'hFFFF_FFFF));
        plan.push_back(cfg_row(CFG_HEADER_BYTES, 32'h0000_FFFF));
        plan.push_back(cfg_row(CFG_TRANSFER_BYTES, 32'h0000_FFFF));
        plan.push_back(typed_row(item_row(48'd1, 4'd4, 1'b1, 16'hFFFF, 32'h4),
                                 1'b1, TIME_MAX, 48'd0, 32'd2));
        plan.push_back(typed_row(item_row(48'd0, 4'd4, 1'b0, 16'h0, 32'h5),
                                 1'b1, TIME_MAX, 48'hFFFF_0000_0001, 32'd2));
        // zero-size packets
        plan.push_back(cfg_row(CFG_HEADER_BYTES, 32'h0));
        plan.push_back(cfg_row(CFG_TRANSFER_BYTES, 32'h0));
        plan.push_back(cfg_row(CFG_LINK_DELAY, 32'h0));
        plan.push_back(item_row(48'd0, 4'd5, 1'b0, 16'h0, 32'h6));
        plan.push_back(item_row(48'd0, 4'd5, 1'b1, 16'hFFFF, 32'h7));

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_CFG) begin
                if (i == 0 || plan[i-1].kind != ROW_CFG)
                    settle();
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            end else begin
                send_item(plan[i]);
            end
        end

        // random phases, each with fresh settings; arrivals follow a running clock
        // so queues build up against the buffer limit
        for (int ph = 0; ph < 8; ph++) begin
            settle();
            idle_on = (ph < 7) && ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 7))
                0:       next_cfg.byte_time = 32'h0;
                1:       next_cfg.byte_time = 32'hFFFF_FFFF;
                default: next_cfg.byte_time = $urandom_range(1, 262144);
            endcase
            case ($urandom_range(0, 7))
                0:       next_cfg.buffer_bytes = 24'h0;
                1:       next_cfg.buffer_bytes = 24'hFF_FFFF;
                default: next_cfg.buffer_bytes = 24'($urandom_range(0, 6000));
            endcase
            next_cfg.link_delay = ($urandom_range(0, 1) == 0) ? 32'h0 : $urandom;
            next_cfg.header_bytes = ($urandom_range(0, 15) == 0) ? 16'hFFFF
                                  : 16'($urandom_range(0, 200));
            next_cfg.transfer_bytes = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                    : 16'($urandom_range(200, 3000));
            write_reg(CFG_BYTE_TIME, next_cfg.byte_time);
            write_reg(CFG_BUFFER_BYTES, 32'(next_cfg.buffer_bytes));
            write_reg(CFG_LINK_DELAY, next_cfg.link_delay);
            write_reg(CFG_HEADER_BYTES, 32'(next_cfg.header_bytes));
            write_reg(CFG_TRANSFER_BYTES, 32'(next_cfg.transfer_bytes));

            clock_now = TIME_W'({$urandom, $urandom});
            stride    = 64'(next_cfg.transfer_bytes) * 64'(next_cfg.byte_time) / 4;
            for (int n = 0; n < 92; n++) begin
                row      = '0;
                row.kind = ROW_ITEM;
                // a tenth of arrivals ignore the running clock
                row.it.now = ($urandom_range(0, 9) == 0) ? TIME_W'({$urandom, $urandom})
                                                         : clock_now;
                row.it.link = ($urandom_range(0, 3) != 0) ? 4'($urandom_range(0, 3))
                                                          : 4'($urandom_range(0, 15));
                row.it.packet_kind  = 1'($urandom_range(0, 1));
                row.it.jitter       = 16'($urandom);
                row.it.source       = 16'($urandom);
                row.it.destination  = 16'($urandom);
                row.it.sequence_req = $urandom;
                row.it.acknowledge  = $urandom;
                send_item(row);
                clock_now = clock_now + TIME_W'((stride * 64'($urandom_range(0, 255))) >> 8)
                          + TIME_W'($urandom_range(0, 3));
            end
        end

        settle();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/ltda_pkg.sv
hw/rtl/ltda_cfg_regs.sv
hw/rtl/ltda_finish_mem.sv
hw/rtl/ltda_datapath.sv
hw/rtl/link_tail_drop_admission.sv
bench/tb_top.sv
